// ===== hdl/mlsc_pkg.sv =====
// Shared types and codes of the MESI line state controller.
package mlsc_pkg;

	localparam int unsigned LINES_DEFAULT = 1024;
	localparam int unsigned OP_W          = 3;
	localparam int unsigned LINE_W        = 10;
	localparam int unsigned NODE_W        = 4;
	localparam int unsigned STATE_W       = 3;
	localparam int unsigned REQ_W         = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 3'd0,
		OP_STORE = 3'd1,
		OP_GETS  = 3'd2,
		OP_GETM  = 3'd3,
		OP_DATA  = 3'd4
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		ST_I   = 3'd0,
		ST_S   = 3'd1,
		ST_E   = 3'd2,
		ST_M   = 3'd3,
		ST_IM  = 3'd4,
		ST_ISE = 3'd5,
		ST_SM  = 3'd6
	} line_state_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_NONE = 2'd0,
		REQ_GETS = 2'd1,
		REQ_GETM = 2'd2
	} bus_req_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LINE_W-1:0] line_index;
		logic [NODE_W-1:0] requester;
		logic              shared_in;
	} msg_t;

	// Actions of one transition, before the line echo is attached.
	typedef struct packed {
		logic [REQ_W-1:0]   bus_request;
		logic               data_to_proc;
		logic               data_on_bus;
		logic [NODE_W-1:0]  data_dest;
		logic               shared_assert;
		logic               miss;
		logic               silent_upgrade;
		logic               error;
		logic [STATE_W-1:0] next_state;
	} act_t;

	typedef struct packed {
		logic [LINE_W-1:0]  line_out;
		logic [REQ_W-1:0]   bus_request;
		logic               data_to_proc;
		logic               data_on_bus;
		logic [NODE_W-1:0]  data_dest;
		logic               shared_assert;
		logic               miss;
		logic               silent_upgrade;
		logic               error;
		logic [STATE_W-1:0] next_state;
	} resp_t;

endpackage

// ===== hdl/mlsc_stream_if.sv =====
// Valid/ready stream channel carrying one word of type T.
interface mlsc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/mlsc_transition.sv =====
// MESI transition logic for one message against one line state.
module mlsc_transition (
	input  logic [mlsc_pkg::STATE_W-1:0] cur,
	input  logic [mlsc_pkg::OP_W-1:0]    op,
	input  logic [mlsc_pkg::NODE_W-1:0]  requester,
	input  logic                         shared_in,
	output mlsc_pkg::act_t               act
);
	import mlsc_pkg::*;

	logic [STATE_W-1:0] cur_n;
	logic               is_store;

	// Treat an unused state code as Invalid.
	assign cur_n    = (cur > ST_SM) ? ST_I : cur;
	assign is_store = (op == OP_STORE);

	always_comb begin
		act            = '0;
		act.next_state = cur_n;
		if (op > OP_DATA) begin
			act.error = 1'b1;
		end else if (op == OP_LOAD || op == OP_STORE) begin
			case (cur_n)
				ST_I: begin
					act.bus_request = is_store ? REQ_GETM : REQ_GETS;
					act.next_state  = is_store ? ST_IM : ST_ISE;
					act.miss        = 1'b1;
				end
				ST_S: begin
					if (is_store) begin
						act.bus_request = REQ_GETM;
						act.next_state  = ST_SM;
						act.miss        = 1'b1;
					end else begin
						act.data_to_proc = 1'b1;
					end
				end
				ST_E: begin
					act.data_to_proc = 1'b1;
					if (is_store) begin
						act.next_state     = ST_M;
						act.silent_upgrade = 1'b1;
					end
				end
				ST_M: begin
					act.data_to_proc = 1'b1;
				end
				default: begin
					// processor request while a transient is outstanding
					act.error = 1'b1;
				end
			endcase
		end else begin
			case (cur_n)
				ST_I: begin
				end
				ST_S: begin
					if (op == OP_DATA) begin
						act.error = 1'b1;
					end else begin
						act.shared_assert = 1'b1;
						if (op == OP_GETM) begin
							act.next_state = ST_I;
						end
					end
				end
				ST_E, ST_M: begin
					if (op == OP_DATA) begin
						act.error = 1'b1;
					end else begin
						act.shared_assert = 1'b1;
						act.data_on_bus   = 1'b1;
						act.next_state    = (op == OP_GETS) ? ST_S : ST_I;
					end
				end
				ST_IM: begin
					if (op == OP_DATA) begin
						act.data_to_proc = 1'b1;
						act.next_state   = ST_M;
					end
				end
				ST_ISE: begin
					if (op == OP_DATA) begin
						act.data_to_proc = 1'b1;
						if (shared_in) begin
							act.shared_assert = 1'b1;
							act.next_state    = ST_S;
						end else begin
							act.next_state = ST_E;
						end
					end
				end
				default: begin
					// SM: a snooped GETM keeps the line in SM
					if (op == OP_DATA) begin
						act.data_to_proc = 1'b1;
						act.next_state   = ST_M;
					end else begin
						act.shared_assert = 1'b1;
					end
				end
			endcase
		end
		act.data_dest = act.data_on_bus ? requester : '0;
	end
endmodule

// ===== hdl/mesi_line_state_controller.sv =====
// Snooping MESI line state controller: state memory, update pipeline, result register.
//
// Sustains one message per cycle while resp is not stalled. A message is accepted while its
// line's state is read from the state memory; the transition is then computed from the
// registered state, and when the output register is free or being drained the new state is
// written back and the result loads the output register. The output register lets a new
// message enter while a result waits. A message to the line updated in the cycle of its
// acceptance takes the new state by forwarding. After reset a clearing pass sets every line
// to Invalid, one line per cycle, during which no message is accepted. Line indexes at or
// above LINES wrap modulo LINES; line_out echoes the index as given.
module mesi_line_state_controller #(
	parameter int unsigned LINES = mlsc_pkg::LINES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	mlsc_stream_if.sink   msg,
	mlsc_stream_if.source resp
);
	import mlsc_pkg::*;

	localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

	function automatic logic [IDX_W-1:0] reduce_index(input logic [LINE_W-1:0] x);
		logic [LINE_W-1:0] r;
		r = x;
		for (int k = LINE_W - 1; k >= 0; k--) begin
			if ((LINES << k) < (1 << LINE_W)) begin
				if (r >= LINE_W'(LINES << k)) begin
					r = r - LINE_W'(LINES << k);
				end
			end
		end
		return IDX_W'(r);
	endfunction

	logic [STATE_W-1:0] mem [LINES];

	logic               clearing_q;
	logic [IDX_W-1:0]   clr_cnt_q;

	logic               valid_s1;
	msg_t               msg_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [STATE_W-1:0] rd_data_s1;
	logic               fwd_s1;
	logic [STATE_W-1:0] fwd_state_s1;

	logic               out_valid_q;
	resp_t              out_q;

	logic               in_fire;
	logic               advance;
	logic [IDX_W-1:0]   rd_addr;
	logic [STATE_W-1:0] cur_state;
	act_t               act;
	logic               item_wr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [STATE_W-1:0] wr_data;

	assign advance   = valid_s1 && (!out_valid_q || resp.ready);
	assign msg.ready = !clearing_q && (!valid_s1 || advance);
	assign in_fire   = msg.valid && msg.ready;
	assign rd_addr   = reduce_index(msg.payload.line_index);
	assign cur_state = fwd_s1 ? fwd_state_s1 : rd_data_s1;

	mlsc_transition u_transition (
		.cur       (cur_state),
		.op        (msg_s1.op),
		.requester (msg_s1.requester),
		.shared_in (msg_s1.shared_in),
		.act       (act)
	);

	// An illegal message leaves the line untouched.
	assign item_wr = advance && !act.error;
	assign wr_en   = clearing_q || item_wr;
	assign wr_addr = clearing_q ? clr_cnt_q : idx_s1;
	assign wr_data = clearing_q ? ST_I : act.next_state;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (in_fire) begin
			rd_data_s1 <= mem[rd_addr];
			msg_s1     <= msg.payload;
			idx_s1     <= rd_addr;
			// the read above misses a write to the same line at this edge
			fwd_state_s1 <= act.next_state;
		end
		if (advance) begin
			out_q.line_out       <= msg_s1.line_index;
			out_q.bus_request    <= act.bus_request;
			out_q.data_to_proc   <= act.data_to_proc;
			out_q.data_on_bus    <= act.data_on_bus;
			out_q.data_dest      <= act.data_dest;
			out_q.shared_assert  <= act.shared_assert;
			out_q.miss           <= act.miss;
			out_q.silent_upgrade <= act.silent_upgrade;
			out_q.error          <= act.error;
			out_q.next_state     <= act.next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
				if (clr_cnt_q == IDX_W'(LINES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= item_wr && (rd_addr == idx_s1);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign resp.valid   = out_valid_q;
	assign resp.payload = out_q;

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !out_valid_q)
		else $error("message in flight during clearing pass");

	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && act.error |-> act.next_state == cur_state && act.bus_request == REQ_NONE)
		else $error("illegal message changed line state or issued a request");

	a_silent_upgrade: assert property (@(posedge clk) disable iff (!arst_n)
		advance && act.silent_upgrade |-> act.next_state == ST_M && act.bus_request == REQ_NONE)
		else $error("silent upgrade without move to M or with bus traffic");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result shown without an update");
endmodule
